>>> hw/rtl/treadmill_command_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the treadmill command sequencer checks
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TREADMILL_COMMAND_SEQUENCER_MACROS_SVH
`define TREADMILL_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication
`define TCS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, codes and frame tables of the treadmill command sequencer.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int NUM_FRAMES  = 29;
    localparam int FRAME_WORDS = 5;

    typedef logic [4:0] frame_id_t;
    typedef logic [2:0] word_idx_t;

    // frame ids: init frames, then poll frames, then the start sequence
    localparam frame_id_t INIT_FRAMES = 5'd18;
    localparam frame_id_t POLL_BASE   = 5'd18;
    localparam frame_id_t START_FIRST = 5'd24;
    localparam frame_id_t START_LAST  = 5'd28;

    localparam word_idx_t LAST_WORD_IDX = 3'd4;

    localparam logic [2:0] POLL_LAST   = 3'd5;
    localparam logic [2:0] CTRL_PHASE  = 3'd2;
    localparam logic [2:0] START_PHASE = 3'd5;

    localparam logic [7:0]  KIND_SPEED   = 8'h01;
    localparam logic [7:0]  KIND_INCLINE = 8'h02;
    localparam logic [7:0]  CKSUM_BIAS   = 8'h12;
    localparam logic [31:0] NOOP_WORD    = 32'hfe020d02;
    localparam logic [31:0] CTRL_W0      = 32'hff0d0204;
    localparam logic [31:0] CTRL_W1      = 32'h02090409;
    localparam logic [15:0] CTRL_HDR     = 16'h0201;

    localparam logic [15:0] SPEED_LIMIT_RST   = 16'd2200;
    localparam logic [15:0] INCLINE_LIMIT_RST = 16'd1500;

    typedef enum logic [0:0] {
        REG_SPEED_LIMIT   = 1'b0,
        REG_INCLINE_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_SPEED   = 3'd1,
        FUNC_INCLINE = 3'd2,
        FUNC_BELT    = 3'd3,
        FUNC_RESTART = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_TAB,
        SEG_INC_NOOP,
        SEG_INC_CTRL,
        SEG_SPD_NOOP,
        SEG_SPD_CTRL
    } seg_t;

    // one tick's worth of work, handed from the front to the back
    typedef struct packed {
        frame_id_t   frame_id;
        logic        inc_en;
        logic [15:0] inc_val;
        logic        spd_en;
        logic [15:0] spd_val;
        logic        start_en;
    } job_t;

    // set where a frame is a single word
    localparam logic [NUM_FRAMES-1:0] FRAME_SHORT = 29'b01001_00100_10010_01000_10001_0001;

    localparam logic [31:0] FRAME_TAB [NUM_FRAMES][FRAME_WORDS] = '{
        '{32'hfe020802, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'hff080204, 32'h02040204, 32'h81870000, 32'h00000000, 32'h00000000},
        '{32'hff080204, 32'h02040404, 32'h80880000, 32'h00000000, 32'h00000000},
        '{32'hff080204, 32'h02040404, 32'h88900000, 32'h00000000, 32'h00000000},
        '{32'hfe020a02, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'hff0a0204, 32'h02060206, 32'h8200008a, 32'h00000000, 32'h00000000},
        '{32'hff0a0204, 32'h02060206, 32'h8400008c, 32'h00000000, 32'h00000000},
        '{32'hff080204, 32'h02040204, 32'h959b0000, 32'h00000000, 32'h00000000},
        '{32'hfe022c04, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'h00120204, 32'h02280428, 32'h900701ce, 32'hc4b0aaa2, 32'ha8949696},
        '{32'h0112aca8, 32'ha2bad0dc, 32'hcefe1400, 32'h3a527864, 32'h86a6fc18},
        '{32'hff08324a, 32'ha0880200, 32'h00440000, 32'h00000000, 32'h00000000},
        '{32'hfe021903, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'h00120204, 32'h02150415, 32'h02000f00, 32'h1000d81c, 32'h480000e0},
        '{32'hff070000, 32'h00100008, 32'h6e000000, 32'h00000000, 32'h00000000},
        '{32'hfe021703, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'h00120204, 32'h02130413, 32'h020c0000, 32'h00000000, 32'h00000000},
        '{32'hff050080, 32'h0000a500, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'hfe021903, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'h00120204, 32'h02150415, 32'h02000f80, 32'h0a410000, 32'h00000000},
        '{32'hff070000, 32'h00810010, 32'h86000000, 32'h00000000, 32'h00000000},
        '{32'hfe021403, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'h00120204, 32'h02100410, 32'h02000a1b, 32'h94300000, 32'h40500080},
        '{32'hff021827, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'hfe022003, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'h00120204, 32'h021c041c, 32'h02090000, 32'h40021840, 32'h00008030},
        '{32'hff0e2a00, 32'h00c72058, 32'h0200b400, 32'h580200ee, 32'h00000000},
        '{32'hfe021102, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'hff110204, 32'h020d040d, 32'h02020310, 32'ha0000000, 32'h0a00d200}
    };

    // word of a control frame; checksum wraps in eight bits
    function automatic logic [31:0] ctrl_word(
        input logic [7:0]  kind,
        input logic [15:0] val,
        input word_idx_t   idx
    );
        logic [7:0] ck;
        ck = val[7:0] + CKSUM_BIAS;
        case (idx)
            3'd0:    ctrl_word = CTRL_W0;
            3'd1:    ctrl_word = CTRL_W1;
            3'd2:    ctrl_word = {CTRL_HDR, kind, val[7:0]};
            3'd3:    ctrl_word = {val[15:8], 8'h00, ck, 8'h00};
            default: ctrl_word = 32'h0;
        endcase
    endfunction

endpackage

>>> hw/rtl/tcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_if
// Valid/ready channels: the event stream in and the frame word stream out.
// ----------------------------------------------------------------------------
interface tcs_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [15:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface tcs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        frame_end;
    logic        last;

    modport source (output valid, output word, output frame_end, output last, input ready);
    modport sink   (input valid, input word, input frame_end, input last, output ready);
endinterface

>>> hw/rtl/treadmill_command_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// treadmill_command_sequencer
// Turns timer ticks and speed, incline and belt events into command frames.
// ----------------------------------------------------------------------------
// Every input event is taken while the two-entry job queue has
// room; speed, incline, belt and restart events only update state and send
// nothing. A tick sends 1 to 22 words: the back sequencer first pulls the
// tick's job from the queue in its idle state and then puts out one word
// per cycle through its output register while the sink holds ready high;
// any cycle in which the sink holds ready low stalls it. The front keeps
// taking events while the back is still sending earlier frames.
module treadmill_command_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    tcs_in_if.sink      cmd,
    tcs_out_if.source   frame,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0]   speed_limit_reg;
    logic [15:0]   speed_limit_next;
    logic [15:0]   incline_limit_reg;
    logic [15:0]   incline_limit_next;

    logic          q_push;
    tcs_pkg::job_t q_job;
    logic          q_pop;
    tcs_pkg::job_t q_head;
    logic          q_full;
    logic          q_empty;

    always_comb
    begin
        speed_limit_next   = speed_limit_reg;
        incline_limit_next = incline_limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tcs_pkg::REG_SPEED_LIMIT:   speed_limit_next   = cfg_data;
                tcs_pkg::REG_INCLINE_LIMIT: incline_limit_next = cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg   <= tcs_pkg::SPEED_LIMIT_RST;
            incline_limit_reg <= tcs_pkg::INCLINE_LIMIT_RST;
        end
        else
        begin
            speed_limit_reg   <= speed_limit_next;
            incline_limit_reg <= incline_limit_next;
        end
    end

    tcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .speed_limit   (speed_limit_reg),
        .incline_limit (incline_limit_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_job)
    );

    tcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tcs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .frame   (frame)
    );

endmodule

>>> hw/rtl/tcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_queue
// Two-entry job queue between the event front and the frame back.
// ----------------------------------------------------------------------------
module tcs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcs_pkg::job_t push_job,
    input  logic          pop,
    output tcs_pkg::job_t head,
    output logic          full,
    output logic          empty
);

    tcs_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/tcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_front
// Takes events, keeps the link state and turns each tick into a job.
// ----------------------------------------------------------------------------
module tcs_front (
    input  logic          clk,
    input  logic          rst_n,
    tcs_in_if.sink        cmd,
    input  logic [15:0]   speed_limit,
    input  logic [15:0]   incline_limit,
    input  logic          q_full,
    output logic          q_push,
    output tcs_pkg::job_t q_job
);

    logic [4:0]  step_reg;
    logic [4:0]  step_next;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic        spd_pend_reg;
    logic        spd_pend_next;
    logic [15:0] spd_req_reg;
    logic [15:0] spd_req_next;
    logic        inc_pend_reg;
    logic        inc_pend_next;
    logic [15:0] inc_req_reg;
    logic [15:0] inc_req_next;
    logic        start_reg;
    logic        start_next;
    logic [15:0] belt_reg;
    logic [15:0] belt_next;

    logic        accept;
    logic [15:0] inc_clamped;
    logic        inc_ok;
    logic        spd_pos;
    logic        spd_ok;
    logic        belt_stopped;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;

    // negative incline goes out as zero
    assign inc_clamped  = inc_req_reg[15] ? 16'h0000 : inc_req_reg;
    assign inc_ok       = (inc_clamped <= incline_limit);
    assign spd_pos      = !spd_req_reg[15] && (spd_req_reg != 16'h0000);
    assign spd_ok       = !spd_req_reg[15] && (spd_req_reg <= speed_limit);
    assign belt_stopped = belt_reg[15] || (belt_reg == 16'h0000);

    always_comb
    begin
        step_next     = step_reg;
        phase_next    = phase_reg;
        spd_pend_next = spd_pend_reg;
        spd_req_next  = spd_req_reg;
        inc_pend_next = inc_pend_reg;
        inc_req_next  = inc_req_reg;
        start_next    = start_reg;
        belt_next     = belt_reg;
        q_push        = 1'b0;
        q_job         = '0;

        if (accept)
        begin
            case (cmd.func)
                tcs_pkg::FUNC_SPEED:
                begin
                    spd_req_next  = cmd.value;
                    spd_pend_next = 1'b1;
                end
                tcs_pkg::FUNC_INCLINE:
                begin
                    inc_req_next  = cmd.value;
                    inc_pend_next = 1'b1;
                end
                tcs_pkg::FUNC_BELT:
                begin
                    belt_next = cmd.value;
                end
                tcs_pkg::FUNC_RESTART:
                begin
                    step_next  = 5'd0;
                    phase_next = 3'd0;
                end
                tcs_pkg::FUNC_TICK:
                begin
                    q_push = 1'b1;
                    if (step_reg < tcs_pkg::INIT_FRAMES)
                    begin
                        q_job.frame_id = step_reg;
                        step_next      = step_reg + 5'd1;
                    end
                    else
                    begin
                        q_job.frame_id = tcs_pkg::POLL_BASE + {2'b00, phase_reg};
                        if (phase_reg == tcs_pkg::CTRL_PHASE)
                        begin
                            if (inc_pend_reg)
                            begin
                                // drop an incline over the limit
                                q_job.inc_en  = inc_ok;
                                q_job.inc_val = inc_clamped;
                                inc_pend_next = 1'b0;
                            end
                            if (spd_pend_reg)
                            begin
                                if (spd_pos && belt_stopped)
                                begin
                                    start_next = 1'b1;
                                end
                                else if (spd_ok)
                                begin
                                    q_job.spd_en  = 1'b1;
                                    q_job.spd_val = spd_req_reg;
                                    spd_pend_next = 1'b0;
                                end
                            end
                        end
                        else if ((phase_reg == tcs_pkg::START_PHASE) && start_reg)
                        begin
                            q_job.start_en = 1'b1;
                            start_next     = 1'b0;
                        end
                        phase_next = (phase_reg == tcs_pkg::POLL_LAST) ? 3'd0
                                                                       : phase_reg + 3'd1;
                    end
                end
                default:
                begin
                    // unknown codes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= 5'd0;
            phase_reg    <= 3'd0;
            spd_pend_reg <= 1'b0;
            spd_req_reg  <= 16'h0000;
            inc_pend_reg <= 1'b0;
            inc_req_reg  <= 16'h0000;
            start_reg    <= 1'b0;
            belt_reg     <= 16'h0000;
        end
        else
        begin
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            spd_pend_reg <= spd_pend_next;
            spd_req_reg  <= spd_req_next;
            inc_pend_reg <= inc_pend_next;
            inc_req_reg  <= inc_req_next;
            start_reg    <= start_next;
            belt_reg     <= belt_next;
        end
    end

endmodule

>>> hw/rtl/tcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_back
// Walks the frames of one job and sends them one word per transfer.
// ----------------------------------------------------------------------------
module tcs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tcs_pkg::job_t head,
    input  logic          q_empty,
    output logic          q_pop,
    tcs_out_if.source     frame
);

    tcs_pkg::seg_t      seg_reg;
    tcs_pkg::seg_t      seg_next;
    tcs_pkg::frame_id_t id_reg;
    tcs_pkg::frame_id_t id_next;
    tcs_pkg::word_idx_t idx_reg;
    tcs_pkg::word_idx_t idx_next;
    logic               inc_en_reg;
    logic               inc_en_next;
    logic [15:0]        inc_val_reg;
    logic [15:0]        inc_val_next;
    logic               spd_en_reg;
    logic               spd_en_next;
    logic [15:0]        spd_val_reg;
    logic [15:0]        spd_val_next;
    logic               start_en_reg;
    logic               start_en_next;
    logic               ovalid_reg;
    logic               ovalid_next;
    logic [31:0]        oword_reg;
    logic [31:0]        oword_next;
    logic               oend_reg;
    logic               oend_next;
    logic               olast_reg;
    logic               olast_next;

    logic               advance;
    logic [31:0]        cur_word;
    logic               cur_end;
    tcs_pkg::seg_t      after_seg;
    tcs_pkg::frame_id_t after_id;
    logic               after_done;

    assign frame.valid     = ovalid_reg;
    assign frame.word      = oword_reg;
    assign frame.frame_end = oend_reg;
    assign frame.last      = olast_reg;

    assign advance = !ovalid_reg || frame.ready;

    // word under the cursor
    always_comb
    begin
        cur_word = 32'h0;
        cur_end  = 1'b0;
        case (seg_reg)
            tcs_pkg::SEG_TAB:
            begin
                cur_word = tcs_pkg::FRAME_TAB[id_reg][idx_reg];
                cur_end  = tcs_pkg::FRAME_SHORT[id_reg] ? (idx_reg == 3'd0)
                                                         : (idx_reg == tcs_pkg::LAST_WORD_IDX);
            end
            tcs_pkg::SEG_INC_NOOP, tcs_pkg::SEG_SPD_NOOP:
            begin
                cur_word = tcs_pkg::NOOP_WORD;
                cur_end  = 1'b1;
            end
            tcs_pkg::SEG_INC_CTRL:
            begin
                cur_word = tcs_pkg::ctrl_word(tcs_pkg::KIND_INCLINE, inc_val_reg, idx_reg);
                cur_end  = (idx_reg == tcs_pkg::LAST_WORD_IDX);
            end
            tcs_pkg::SEG_SPD_CTRL:
            begin
                cur_word = tcs_pkg::ctrl_word(tcs_pkg::KIND_SPEED, spd_val_reg, idx_reg);
                cur_end  = (idx_reg == tcs_pkg::LAST_WORD_IDX);
            end
            default:
            begin
                cur_word = 32'h0;
                cur_end  = 1'b0;
            end
        endcase
    end

    // frame that follows the current one
    always_comb
    begin
        after_seg  = tcs_pkg::SEG_IDLE;
        after_id   = id_reg;
        after_done = 1'b0;
        if ((seg_reg == tcs_pkg::SEG_TAB) && (id_reg >= tcs_pkg::START_FIRST)
            && (id_reg < tcs_pkg::START_LAST))
        begin
            after_seg = tcs_pkg::SEG_TAB;
            after_id  = id_reg + 5'd1;
        end
        else if (seg_reg == tcs_pkg::SEG_INC_NOOP)
        begin
            after_seg = tcs_pkg::SEG_INC_CTRL;
        end
        else if (seg_reg == tcs_pkg::SEG_SPD_NOOP)
        begin
            after_seg = tcs_pkg::SEG_SPD_CTRL;
        end
        else if (inc_en_reg)
        begin
            after_seg = tcs_pkg::SEG_INC_NOOP;
        end
        else if (spd_en_reg)
        begin
            after_seg = tcs_pkg::SEG_SPD_NOOP;
        end
        else if (start_en_reg)
        begin
            after_seg = tcs_pkg::SEG_TAB;
            after_id  = tcs_pkg::START_FIRST;
        end
        else
        begin
            after_done = 1'b1;
        end
    end

    always_comb
    begin
        seg_next      = seg_reg;
        id_next       = id_reg;
        idx_next      = idx_reg;
        inc_en_next   = inc_en_reg;
        inc_val_next  = inc_val_reg;
        spd_en_next   = spd_en_reg;
        spd_val_next  = spd_val_reg;
        start_en_next = start_en_reg;
        ovalid_next   = ovalid_reg && !frame.ready;
        oword_next    = oword_reg;
        oend_next     = oend_reg;
        olast_next    = olast_reg;
        q_pop         = 1'b0;

        case (seg_reg)
            tcs_pkg::SEG_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    seg_next      = tcs_pkg::SEG_TAB;
                    id_next       = head.frame_id;
                    idx_next      = 3'd0;
                    inc_en_next   = head.inc_en;
                    inc_val_next  = head.inc_val;
                    spd_en_next   = head.spd_en;
                    spd_val_next  = head.spd_val;
                    start_en_next = head.start_en;
                end
            end
            default:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = cur_word;
                    oend_next   = cur_end;
                    olast_next  = cur_end && after_done;
                    if (!cur_end)
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                    else
                    begin
                        idx_next = 3'd0;
                        seg_next = after_seg;
                        id_next  = after_id;
                        // consume the flag of the segment just entered
                        if (after_seg == tcs_pkg::SEG_INC_NOOP)
                        begin
                            inc_en_next = 1'b0;
                        end
                        if (after_seg == tcs_pkg::SEG_SPD_NOOP)
                        begin
                            spd_en_next = 1'b0;
                        end
                        if ((after_seg == tcs_pkg::SEG_TAB)
                            && (after_id == tcs_pkg::START_FIRST))
                        begin
                            start_en_next = 1'b0;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg      <= tcs_pkg::SEG_IDLE;
            id_reg       <= 5'd0;
            idx_reg      <= 3'd0;
            inc_en_reg   <= 1'b0;
            spd_en_reg   <= 1'b0;
            start_en_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            seg_reg      <= seg_next;
            id_reg       <= id_next;
            idx_reg      <= idx_next;
            inc_en_reg   <= inc_en_next;
            spd_en_reg   <= spd_en_next;
            start_en_reg <= start_en_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_val_reg <= inc_val_next;
        spd_val_reg <= spd_val_next;
        oword_reg   <= oword_next;
        oend_reg    <= oend_next;
        olast_reg   <= olast_next;
    end

endmodule

>>> hw/rtl/tcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks of the treadmill command sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "treadmill_command_sequencer_macros.svh"

module tcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [2:0]  cmd_func,
    input logic        frame_valid,
    input logic        frame_ready,
    input logic [31:0] frame_word,
    input logic        frame_end,
    input logic        frame_last
);

    logic [3:0] open_reg;
    logic [3:0] open_next;
    logic [2:0] wcnt_reg;
    logic [2:0] wcnt_next;
    logic       tick_in;
    logic       tick_done;
    logic       word_out;

    assign tick_in   = cmd_valid && cmd_ready && (cmd_func == tcs_pkg::FUNC_TICK);
    assign word_out  = frame_valid && frame_ready;
    assign tick_done = word_out && frame_last;

    always_comb
    begin
        open_next = open_reg + {3'b000, tick_in} - {3'b000, tick_done};
        wcnt_next = wcnt_reg;
        if (word_out)
        begin
            wcnt_next = frame_end ? 3'd0 : wcnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 4'd0;
            wcnt_reg <= 3'd0;
        end
        else
        begin
            open_reg <= open_next;
            wcnt_reg <= wcnt_next;
        end
    end

    `TCS_ASSERT_NEXT(a_hold_stalled, frame_valid && !frame_ready, frame_valid && $stable(frame_word) && $stable(frame_end) && $stable(frame_last), "stalled frame word changed")
    `TCS_ASSERT_IMPLY(a_last_ends_frame, frame_valid && frame_last, frame_end, "last word is not a frame end")
    `TCS_ASSERT_IMPLY(a_word_has_tick, frame_valid, open_reg != 4'd0, "word sent with no tick open")
    `TCS_ASSERT_IMPLY(a_frame_len, word_out && (wcnt_reg == 3'd4), frame_end, "frame longer than five words")

endmodule

bind treadmill_command_sequencer tcs_checker u_tcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_func    (cmd.func),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_word  (frame.word),
    .frame_end   (frame.frame_end),
    .frame_last  (frame.last)
);
